/* rtl/ssra_pkg.sv */
// Package for the shadowed serial register access block.
// Field widths, frame constants, request and register codes, shared structs.
// No dependencies.
`default_nettype none

package ssra_pkg;

   localparam int TYPE_W       = 3;
   localparam int ADDR_W       = 5;
   localparam int FIELD_DATA_W = 25;
   localparam int FRAME_W      = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   localparam int DEF_NUM_REGS  = 32;
   localparam int DEF_DATA_BITS = 25;

   localparam logic [FRAME_W-1:0] WRITE_FLAG = 32'h8000_0000;
   localparam int                 ADDR_SHIFT = 26;

   typedef enum logic [TYPE_W-1:0] {
      OP_WRITE           = 3'd0,
      OP_READ            = 3'd1,
      OP_BIT_SET         = 3'd2,
      OP_BIT_CLEAR       = 3'd3,
      OP_DEV_BIT_READ    = 3'd4,
      OP_SHADOW_BIT_READ = 3'd5,
      OP_SHADOW_REG_READ = 3'd6
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VALID_REG_MASK   = 2'd0,
      CSR_STATUS_REG_ADDR  = 2'd1,
      CSR_RX_LINE_INV      = 2'd2,
      CSR_SELECT_LINE_INV  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TYPE_W-1:0]       req_type;
      logic [ADDR_W-1:0]       reg_addr;
      logic [FIELD_DATA_W-1:0] write_data;
      logic [FIELD_DATA_W-1:0] bit_mask;
      logic [FIELD_DATA_W-1:0] rx_bits;
   } req_item_type;

   typedef struct packed {
      logic                    frame_sent;
      logic [FRAME_W-1:0]      tx_frame;
      logic [FIELD_DATA_W-1:0] read_value;
      logic                    bit_result;
      logic                    status;
   } rsp_item_type;

   typedef struct packed {
      logic [FRAME_W-1:0] valid_reg_mask;
      logic [ADDR_W-1:0]  status_reg_addr;
      logic               rx_line_inverted;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/ssra_req_if.sv */
// Request channel interface: valid/ready plus request fields.
// Depends on ssra_pkg.
`default_nettype none

interface ssra_req_if
   import ssra_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [TYPE_W-1:0]       req_type;
   logic [ADDR_W-1:0]       reg_addr;
   logic [FIELD_DATA_W-1:0] write_data;
   logic [FIELD_DATA_W-1:0] bit_mask;
   logic [FIELD_DATA_W-1:0] rx_bits;

   modport source (output valid, req_type, reg_addr, write_data, bit_mask, rx_bits,
                   input ready);
   modport sink   (input valid, req_type, reg_addr, write_data, bit_mask, rx_bits,
                   output ready);
endinterface

`default_nettype wire

/* rtl/ssra_rsp_if.sv */
// Response channel interface: valid/ready plus result fields.
// Depends on ssra_pkg.
`default_nettype none

interface ssra_rsp_if
   import ssra_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    frame_sent;
   logic [FRAME_W-1:0]      tx_frame;
   logic [FIELD_DATA_W-1:0] read_value;
   logic                    bit_result;
   logic                    status;

   modport source (output valid, frame_sent, tx_frame, read_value, bit_result, status,
                   input ready);
   modport sink   (input valid, frame_sent, tx_frame, read_value, bit_result, status,
                   output ready);
endinterface

`default_nettype wire

/* rtl/ssra_shadow.sv */
// Shadow register store: flop array with per-entry valid bits, one read, one write.
// Depends on ssra_pkg.
`default_nettype none

module ssra_shadow
   import ssra_pkg::*;
#(
   parameter int NUM_REGS  = DEF_NUM_REGS,
   parameter int DATA_BITS = DEF_DATA_BITS,
   localparam int IDX_W    = $clog2(NUM_REGS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [IDX_W-1:0]     rd_idx,
   output      logic [DATA_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [IDX_W-1:0]     wr_idx,
   input  wire logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] entry_ff [NUM_REGS];
   logic [NUM_REGS-1:0]  vld_ff;

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = vld_ff[rd_idx] ? entry_ff[rd_idx] : '0;

endmodule

`default_nettype wire

/* rtl/ssra_exec.sv */
// Request decode and shadow read-modify-write, one request per cycle.
// Depends on ssra_pkg; reads and writes the store in ssra_shadow.
`default_nettype none

module ssra_exec
   import ssra_pkg::*;
#(
   parameter int NUM_REGS  = DEF_NUM_REGS,
   parameter int DATA_BITS = DEF_DATA_BITS,
   localparam int IDX_W    = $clog2(NUM_REGS)
) (
   input  wire req_item_type         req,
   input  wire cfg_type              cfg,
   input  wire logic [DATA_BITS-1:0] rd_data,
   output      logic [IDX_W-1:0]     rd_idx,
   output      logic                 wr_en,
   output      logic [IDX_W-1:0]     wr_idx,
   output      logic [DATA_BITS-1:0] wr_data,
   output      rsp_item_type         rsp
);

   localparam logic [FRAME_W-1:0] DATA_MASK = 32'((64'd1 << DATA_BITS) - 64'd1);

   logic               addr_ok;
   logic               op_known;
   logic [FRAME_W-1:0] wd_w, bm_w, rx_w, cur_w, base_w, set_w, clr_w, new_w;
   logic [FRAME_W-1:0] addr_field;

   assign addr_ok  = (32'(req.reg_addr) < 32'(NUM_REGS)) && cfg.valid_reg_mask[req.reg_addr];
   assign op_known = req.req_type <= OP_SHADOW_REG_READ;

   assign rd_idx = req.reg_addr[IDX_W-1:0];
   assign wr_idx = req.reg_addr[IDX_W-1:0];

   assign wd_w  = 32'(req.write_data) & DATA_MASK;
   assign bm_w  = 32'(req.bit_mask) & DATA_MASK;
   assign rx_w  = (32'(req.rx_bits) & DATA_MASK) ^ (cfg.rx_line_inverted ? DATA_MASK : '0);
   assign cur_w = 32'(rd_data);

   // interrupt status is write-one-to-clear: start from zero
   assign base_w = (req.reg_addr == cfg.status_reg_addr) ? '0 : cur_w;
   assign set_w  = (base_w | bm_w) & DATA_MASK;
   assign clr_w  = (base_w & ~bm_w) & DATA_MASK;

   assign addr_field = 32'(req.reg_addr) << ADDR_SHIFT;

   always_comb begin
      rsp     = '0;
      wr_en   = 1'b0;
      new_w   = '0;
      if (op_known && !addr_ok) begin
         rsp.status = 1'b1;
      end else if (addr_ok) begin
         unique case (op_type'(req.req_type))
            OP_WRITE: begin
               new_w          = wd_w;
               wr_en          = 1'b1;
               rsp.frame_sent = 1'b1;
               rsp.tx_frame   = WRITE_FLAG | addr_field | wd_w;
            end
            OP_READ: begin
               new_w          = rx_w;
               wr_en          = 1'b1;
               rsp.frame_sent = 1'b1;
               rsp.tx_frame   = addr_field;
            end
            OP_BIT_SET, OP_BIT_CLEAR: begin
               new_w          = (req.req_type == OP_BIT_SET) ? set_w : clr_w;
               wr_en          = 1'b1;
               rsp.frame_sent = 1'b1;
               rsp.tx_frame   = WRITE_FLAG | addr_field | new_w;
            end
            OP_DEV_BIT_READ: begin
               new_w          = rx_w;
               wr_en          = 1'b1;
               rsp.frame_sent = 1'b1;
               rsp.tx_frame   = addr_field;
               rsp.bit_result = |(rx_w & bm_w);
            end
            OP_SHADOW_BIT_READ: begin
               rsp.bit_result = |(cur_w & bm_w);
            end
            OP_SHADOW_REG_READ: begin
               new_w = cur_w & DATA_MASK;
            end
            default: begin
               // unused request code: no frame, nothing reported
            end
         endcase
      end
      rsp.read_value = new_w[FIELD_DATA_W-1:0];
   end

   assign wr_data = new_w[DATA_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/shadowed_serial_register_access.sv */
// Shadowed serial register access master: top level with channel registers and CSRs.
// Depends on ssra_pkg, ssra_req_if, ssra_rsp_if, ssra_shadow, ssra_exec.
//
// Usage:
//  - req_ch carries one request transaction (type, address, write data, bit mask and the
//    raw bits the device returns for a read frame). rsp_ch carries one result transaction
//    per request: frame flag, 32-bit frame word, read value, bit test result, status.
//  - csr_we/csr_index/csr_wdata write the configuration registers: 0 valid address mask,
//    1 interrupt status address, 2 receive line inversion, 3 select line polarity. Index 3
//    is taken and has no effect on any result. Write only while the block is idle.
//  - Flow: an accepted request is registered in the input register, and its result moves
//    into the output register once that is empty or being drained; rsp_ch.valid then
//    rises and the result can be taken.
//  - Throughput: one transaction per cycle while rsp_ch.ready is high. The shadow
//    read-modify-write of one request sits in the combinational logic between the input
//    register and the result register, which is what sets the rate.
//  - Stall: if rsp_ch.ready is low the result holds; one more request is parked in the
//    input register, then req_ch.ready drops until the output drains.
//  - Reset (synchronous, active high): both channel registers empty, CSRs at defaults
//    (all addresses valid, status address 0, no inversion), shadow store reads all zero.
`default_nettype none

module shadowed_serial_register_access
   import ssra_pkg::*;
#(
   parameter int NUM_REGS  = DEF_NUM_REGS,
   parameter int DATA_BITS = DEF_DATA_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ssra_req_if.sink                    req_ch,
   ssra_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(NUM_REGS);

   // configuration registers
   logic [FRAME_W-1:0] valid_mask_ff;
   logic [ADDR_W-1:0]  status_addr_ff;
   logic               rx_inv_ff;
   cfg_type            cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mask_ff  <= '1;
         status_addr_ff <= '0;
         rx_inv_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_VALID_REG_MASK:  valid_mask_ff  <= csr_wdata[FRAME_W-1:0];
            CSR_STATUS_REG_ADDR: status_addr_ff <= csr_wdata[ADDR_W-1:0];
            CSR_RX_LINE_INV:     rx_inv_ff      <= csr_wdata[0];
            CSR_SELECT_LINE_INV: begin
               // select pin polarity only; no pin on this block
            end
         endcase
      end
   end

   assign cfg.valid_reg_mask   = valid_mask_ff;
   assign cfg.status_reg_addr  = status_addr_ff;
   assign cfg.rx_line_inverted = rx_inv_ff;

   // input register
   logic         s1_vld_ff;
   req_item_type s1_req_ff;
   // result register
   logic         rsp_vld_ff;
   rsp_item_type rsp_ff;

   logic         advance;
   logic         req_take;
   rsp_item_type exec_rsp;

   assign advance      = s1_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_vld_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_vld_ff <= 1'b1;
         end else if (advance) begin
            s1_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.req_type   <= req_ch.req_type;
         s1_req_ff.reg_addr   <= req_ch.reg_addr;
         s1_req_ff.write_data <= req_ch.write_data;
         s1_req_ff.bit_mask   <= req_ch.bit_mask;
         s1_req_ff.rx_bits    <= req_ch.rx_bits;
      end
      if (advance) begin
         rsp_ff <= exec_rsp;
      end
   end

   // shadow store and request logic
   logic [IDX_W-1:0]     rd_idx, wr_idx;
   logic [DATA_BITS-1:0] rd_data, wr_data;
   logic                 exec_wr_en;

   ssra_exec #(
      .NUM_REGS  (NUM_REGS),
      .DATA_BITS (DATA_BITS)
   ) u_exec (
      .req     (s1_req_ff),
      .cfg     (cfg),
      .rd_data (rd_data),
      .rd_idx  (rd_idx),
      .wr_en   (exec_wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rsp     (exec_rsp)
   );

   // the store only changes when the request moves on to the result register
   ssra_shadow #(
      .NUM_REGS  (NUM_REGS),
      .DATA_BITS (DATA_BITS)
   ) u_shadow (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (exec_wr_en && advance),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.frame_sent = rsp_ff.frame_sent;
   assign rsp_ch.tx_frame   = rsp_ff.tx_frame;
   assign rsp_ch.read_value = rsp_ff.read_value;
   assign rsp_ch.bit_result = rsp_ff.bit_result;
   assign rsp_ch.status     = rsp_ff.status;

   // a new result only appears after a request left the input register
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(advance))
      else $error("result appeared without a request moving on");

   // rejected address never produces a frame
   a_err_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.status |-> !rsp_ff.frame_sent && (rsp_ff.tx_frame == '0))
      else $error("frame reported for an invalid address");

   // both registers full and output stalled: no more requests taken
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_vld_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while pipeline is full");

endmodule

`default_nettype wire
